FILE: rtl/core/flood_forward_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// flood forward filter assertion macros
// Concurrent check wrappers; defining NO_ASSERTIONS removes every check.
// ----------------------------------------------------------------------------
`ifndef FLOOD_FORWARD_FILTER_UNIT_MACROS_SVH
`define FLOOD_FORWARD_FILTER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// check that holds outside reset
`define FFU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that holds at every edge, reset included
`define FFU_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFU_ASSERT(name, prop, msg)
`define FFU_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

FILE: rtl/core/ffu_pkg.sv
// ----------------------------------------------------------------------------
// ffu_pkg
// Shared widths, codes, reset values and control structs of the flood filter.
// ----------------------------------------------------------------------------
package ffu_pkg;

  localparam int SEEN_DEPTH_DEF     = 32;
  localparam int NEIGHBOR_DEPTH_DEF = 20;

  localparam int CALL_W     = 56;
  localparam int ID_W       = 16;
  localparam int HOP_W      = 8;
  localparam int SIG_W      = 9;
  localparam int TIME_W     = 32;
  localparam int PREF_W     = 5;
  localparam int CNT_OUT_W  = 5;
  localparam int VERD_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // verdict codes
  localparam logic [VERD_W-1:0] VERD_FWD     = 3'd0;
  localparam logic [VERD_W-1:0] VERD_DUP     = 3'd1;
  localparam logic [VERD_W-1:0] VERD_HOP     = 3'd2;
  localparam logic [VERD_W-1:0] VERD_WEAK    = 3'd3;
  localparam logic [VERD_W-1:0] VERD_NOTPREF = 3'd4;
  localparam logic [VERD_W-1:0] VERD_CLEAN   = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RSSI = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREF     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd2;

  // register reset values
  localparam logic signed [SIG_W-1:0] MIN_RSSI_RST = -9'sd105;
  localparam logic [PREF_W-1:0]       PREF_RST     = 5'd3;
  localparam logic [TIME_W-1:0]       TIMEOUT_RST  = 32'd60000;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic nbr_scan;
    logic seen_write;
    logic nbr_write;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic dup;
    logic cleanup;
    logic out_busy;
  } stat_t;

endpackage

FILE: rtl/core/ffu_ram.sv
// ----------------------------------------------------------------------------
// ffu_ram
// Single port RAM with registered read data.
// ----------------------------------------------------------------------------
module ffu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read first: read data is registered and shows the old contents during a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/ffu_ctrl.sv
// ----------------------------------------------------------------------------
// ffu_ctrl
// Sequencer: seen/cleanup scan, neighbor scan, table writes, result hand-off.
// ----------------------------------------------------------------------------
module ffu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ffu_pkg::stat_t stat,
  output ffu_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_NBR,
    ST_FIN
  } state_t;

  state_t state;
  state_t state_next;

  // command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (stat.scan_done) begin
          if (stat.cleanup || stat.dup) begin
            state_next = ST_FIN;
          end else begin
            cmd.seen_write = 1'b1;
            cmd.nbr_scan   = 1'b1;
            state_next     = ST_NBR;
          end
        end
      end
      ST_NBR: begin
        if (stat.scan_done) begin
          cmd.nbr_write = 1'b1;
          state_next    = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == ST_IDLE);
    end
  end

endmodule

FILE: rtl/core/ffu_dp.sv
// ----------------------------------------------------------------------------
// ffu_dp
// Datapath: config registers, seen cache and neighbor table, scan and result.
// ----------------------------------------------------------------------------
module ffu_dp #(
  parameter int SEEN_DEPTH     = ffu_pkg::SEEN_DEPTH_DEF,
  parameter int NEIGHBOR_DEPTH = ffu_pkg::NEIGHBOR_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic [ffu_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ffu_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  mode,
  input  logic [ffu_pkg::CALL_W-1:0]            src_call,
  input  logic [ffu_pkg::ID_W-1:0]              message_id,
  input  logic [ffu_pkg::HOP_W-1:0]             hop_limit,
  input  logic signed [ffu_pkg::SIG_W-1:0]      signal_dbm,
  input  logic [ffu_pkg::TIME_W-1:0]            time_ms,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ffu_pkg::VERD_W-1:0]            verdict,
  output logic [ffu_pkg::HOP_W-1:0]             hop_out,
  output logic [ffu_pkg::CNT_OUT_W-1:0]         stronger_count,
  input  ffu_pkg::cmd_t                         cmd,
  output ffu_pkg::stat_t                        stat
);

  localparam int SW    = $clog2(SEEN_DEPTH);
  localparam int NW    = $clog2(NEIGHBOR_DEPTH);
  localparam int IW    = (SW > NW) ? SW : NW;
  localparam int CW    = $clog2(NEIGHBOR_DEPTH + 1);
  localparam int SEEN_W = ffu_pkg::CALL_W + ffu_pkg::ID_W;
  localparam int NBR_W  = ffu_pkg::CALL_W + ffu_pkg::SIG_W + ffu_pkg::TIME_W;

  // config registers
  logic signed [ffu_pkg::SIG_W-1:0] min_rssi;
  logic [ffu_pkg::PREF_W-1:0]       pref;
  logic [ffu_pkg::TIME_W-1:0]       timeout;

  // captured word
  logic                             mode_q;
  logic [ffu_pkg::CALL_W-1:0]       call_q;
  logic [ffu_pkg::ID_W-1:0]         id_q;
  logic [ffu_pkg::HOP_W-1:0]        hop_q;
  logic signed [ffu_pkg::SIG_W-1:0] sig_q;
  logic [ffu_pkg::TIME_W-1:0]       time_q;

  // valid bits and ring pointer
  logic [SEEN_DEPTH-1:0]     seen_valid;
  logic [NEIGHBOR_DEPTH-1:0] nbr_valid;
  logic [SW-1:0]             seen_ptr;

  // scan control
  logic          scan_on;
  logic          scan_seen;
  logic [IW-1:0] idx;
  logic [IW-1:0] last_idx;
  logic          chk_on;
  logic          chk_last;
  logic [IW-1:0] chk_idx;
  logic          done;

  // scan accumulators
  logic                     dup;
  logic                     match;
  logic [NW-1:0]            match_idx;
  logic                     free;
  logic [NW-1:0]            free_idx;
  logic [NW-1:0]            old_idx;
  logic [ffu_pkg::TIME_W-1:0] old_stamp;
  logic                     old_str;
  logic [CW-1:0]            stronger;

  // memory ports
  logic              seen_we;
  logic [SW-1:0]     seen_addr;
  logic [SEEN_W-1:0] seen_q;
  logic              nbr_we;
  logic [NW-1:0]     nbr_addr;
  logic [NW-1:0]     nbr_tgt;
  logic [NBR_W-1:0]  nbr_q;

  // entry fields
  logic [ffu_pkg::CALL_W-1:0]       e_call;
  logic signed [ffu_pkg::SIG_W-1:0] e_rssi;
  logic [ffu_pkg::TIME_W-1:0]       e_stamp;
  logic [ffu_pkg::TIME_W-1:0]       e_age;
  logic                             e_valid;
  logic                             e_str;

  // final rank
  logic [CW-1:0] rank;
  logic          is_out_busy;

  assign e_call  = nbr_q[NBR_W-1 -: ffu_pkg::CALL_W];
  assign e_rssi  = $signed(nbr_q[ffu_pkg::TIME_W +: ffu_pkg::SIG_W]);
  assign e_stamp = nbr_q[ffu_pkg::TIME_W-1:0];
  assign e_age   = time_q - e_stamp;
  assign e_valid = nbr_valid[chk_idx[NW-1:0]];
  assign e_str   = (e_rssi > sig_q);

  assign seen_we   = cmd.seen_write;
  assign seen_addr = seen_we ? seen_ptr : idx[SW-1:0];
  assign nbr_we    = cmd.nbr_write;
  assign nbr_tgt   = match ? match_idx : (free ? free_idx : old_idx);
  assign nbr_addr  = nbr_we ? nbr_tgt : idx[NW-1:0];
  assign rank      = stronger - CW'(!match && !free && old_str);

  assign is_out_busy   = out_valid && !out_ready;
  assign stat.scan_done = done;
  assign stat.dup       = dup;
  assign stat.cleanup   = mode_q;
  assign stat.out_busy  = is_out_busy;

  ffu_ram #(.WIDTH(SEEN_W), .DEPTH(SEEN_DEPTH)) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .addr  (seen_addr),
    .wdata ({call_q, id_q}),
    .rdata (seen_q)
  );

  ffu_ram #(.WIDTH(NBR_W), .DEPTH(NEIGHBOR_DEPTH)) u_nbr_ram (
    .clk   (clk),
    .we    (nbr_we),
    .addr  (nbr_addr),
    .wdata ({call_q, sig_q, time_q}),
    .rdata (nbr_q)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_rssi <= ffu_pkg::MIN_RSSI_RST;
      pref     <= ffu_pkg::PREF_RST;
      timeout  <= ffu_pkg::TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ffu_pkg::REG_MIN_RSSI: min_rssi <= $signed(cfg_data[ffu_pkg::SIG_W-1:0]);
        ffu_pkg::REG_PREF:     pref     <= cfg_data[ffu_pkg::PREF_W-1:0];
        ffu_pkg::REG_TIMEOUT:  timeout  <= cfg_data[ffu_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      call_q <= src_call;
      id_q   <= message_id;
      hop_q  <= hop_limit;
      sig_q  <= signal_dbm;
      time_q <= time_ms;
    end
  end

  // scan issue, check stage, table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q     <= 1'b0;
      seen_valid <= '0;
      nbr_valid  <= '0;
      seen_ptr   <= '0;
      scan_on    <= 1'b0;
      scan_seen  <= 1'b0;
      idx        <= '0;
      last_idx   <= '0;
      chk_on     <= 1'b0;
      chk_last   <= 1'b0;
      chk_idx    <= '0;
      done       <= 1'b0;
      dup        <= 1'b0;
      match      <= 1'b0;
      match_idx  <= '0;
      free       <= 1'b0;
      free_idx   <= '0;
      old_idx    <= '0;
      old_stamp  <= '0;
      old_str    <= 1'b0;
      stronger   <= '0;
    end else begin
      // scan finished once the last entry is checked
      done <= chk_on && chk_last;
      // start of a scan
      if (cmd.load || cmd.nbr_scan) begin
        scan_on   <= 1'b1;
        idx       <= '0;
        dup       <= 1'b0;
        match     <= 1'b0;
        free      <= 1'b0;
        stronger  <= '0;
        old_idx   <= '0;
        old_str   <= 1'b0;
        old_stamp <= '0;
      end
      if (cmd.load) begin
        mode_q    <= mode;
        scan_seen <= !mode;
        last_idx  <= mode ? IW'(NEIGHBOR_DEPTH - 1) : IW'(SEEN_DEPTH - 1);
      end
      if (cmd.nbr_scan) begin
        scan_seen <= 1'b0;
        last_idx  <= IW'(NEIGHBOR_DEPTH - 1);
      end
      // read issue
      chk_on <= scan_on;
      if (scan_on) begin
        chk_idx  <= idx;
        chk_last <= (idx == last_idx);
        idx      <= idx + 1'b1;
        if (idx == last_idx) begin
          scan_on <= 1'b0;
        end
      end
      // check stage on registered read data
      if (chk_on) begin
        if (scan_seen) begin
          if (seen_valid[chk_idx[SW-1:0]] && (seen_q == {call_q, id_q})) begin
            dup <= 1'b1;
          end
        end else if (mode_q) begin
          if (e_valid && (e_age > timeout)) begin
            nbr_valid[chk_idx[NW-1:0]] <= 1'b0;
          end
        end else begin
          if (e_valid) begin
            if (e_call == call_q) begin
              match     <= 1'b1;
              match_idx <= chk_idx[NW-1:0];
            end else if (e_str) begin
              stronger <= stronger + 1'b1;
            end
          end else if (!free) begin
            free     <= 1'b1;
            free_idx <= chk_idx[NW-1:0];
          end
          // oldest stamp, lowest index on ties
          if ((chk_idx == '0) || (e_stamp < old_stamp)) begin
            old_idx   <= chk_idx[NW-1:0];
            old_stamp <= e_stamp;
            old_str   <= e_str;
          end
        end
      end
      // seen cache ring write
      if (seen_we) begin
        seen_valid[seen_ptr] <= 1'b1;
        seen_ptr <= (seen_ptr == SW'(SEEN_DEPTH - 1)) ? '0 : seen_ptr + 1'b1;
      end
      if (nbr_we) begin
        nbr_valid[nbr_tgt] <= 1'b1;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hop_out        <= hop_q;
      stronger_count <= '0;
      if (mode_q) begin
        verdict <= ffu_pkg::VERD_CLEAN;
      end else if (dup) begin
        verdict <= ffu_pkg::VERD_DUP;
      end else if (hop_q <= ffu_pkg::HOP_W'(1)) begin
        verdict <= ffu_pkg::VERD_HOP;
      end else if (sig_q < min_rssi) begin
        verdict <= ffu_pkg::VERD_WEAK;
      end else begin
        stronger_count <= ffu_pkg::CNT_OUT_W'(rank);
        if (32'(rank) < 32'(pref)) begin
          verdict <= ffu_pkg::VERD_FWD;
          hop_out <= hop_q - 1'b1;
        end else begin
          verdict <= ffu_pkg::VERD_NOTPREF;
        end
      end
    end
  end

endmodule

FILE: rtl/core/flood_forward_filter_unit.sv
// ----------------------------------------------------------------------------
// flood_forward_filter_unit
// Forward / drop decision for received mesh frame headers.
// ----------------------------------------------------------------------------
// One word is taken at a time. A frame header scans the seen cache, one entry
// per cycle, then the neighbor table, one entry per cycle; a duplicate or a
// cleanup word scans only the one table. The single read port of each table
// RAM sets this scan rate. The next word is taken while a finished result
// still waits in the output register. Both tables need no clearing pass
// after reset.
`include "flood_forward_filter_unit_macros.svh"

module flood_forward_filter_unit #(
  parameter int SEEN_DEPTH     = ffu_pkg::SEEN_DEPTH_DEF,
  parameter int NEIGHBOR_DEPTH = ffu_pkg::NEIGHBOR_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ffu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ffu_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             mode,
  input  logic [ffu_pkg::CALL_W-1:0]       src_call,
  input  logic [ffu_pkg::ID_W-1:0]         message_id,
  input  logic [ffu_pkg::HOP_W-1:0]        hop_limit,
  input  logic signed [ffu_pkg::SIG_W-1:0] signal_dbm,
  input  logic [ffu_pkg::TIME_W-1:0]       time_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ffu_pkg::VERD_W-1:0]       verdict,
  output logic [ffu_pkg::HOP_W-1:0]        hop_out,
  output logic [ffu_pkg::CNT_OUT_W-1:0]    stronger_count
);

  ffu_pkg::cmd_t  cmd;
  ffu_pkg::stat_t stat;

  // config writes always taken
  assign cfg_ready = 1'b1;

  ffu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffu_dp #(
    .SEEN_DEPTH     (SEEN_DEPTH),
    .NEIGHBOR_DEPTH (NEIGHBOR_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mode           (mode),
    .src_call       (src_call),
    .message_id     (message_id),
    .hop_limit      (hop_limit),
    .signal_dbm     (signal_dbm),
    .time_ms        (time_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .verdict        (verdict),
    .hop_out        (hop_out),
    .stronger_count (stronger_count),
    .cmd            (cmd),
    .stat           (stat)
  );

  // one word in flight
  `FFU_ASSERT(a_one_word, in_valid && in_ready |=> !in_ready, "second word taken during scan")
  // rank only reported with forward or not preferred
  `FFU_ASSERT(a_rank_zero, out_valid && (verdict == ffu_pkg::VERD_DUP || verdict == ffu_pkg::VERD_HOP || verdict == ffu_pkg::VERD_WEAK || verdict == ffu_pkg::VERD_CLEAN) |-> stronger_count == '0, "rank on dropped word")
  // forwarded word had hop limit above one
  `FFU_ASSERT(a_fwd_hop, out_valid && verdict == ffu_pkg::VERD_FWD |-> hop_out != '0, "forwarded with expired hop")
  // no result right out of reset
  `FFU_ASSERT_ALWAYS(a_rst_out, rst |=> !out_valid, "result after reset")

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// flood forward filter testbench
// Sends frame header and cleanup words with random idling on both sides,
// changes the thresholds between phases, and checks every verdict word
// against a behavioral copy of the seen cache and neighbor table.
// ----------------------------------------------------------------------------
import ffu_pkg::*;

class forward_scoreboard;
  typedef struct {
    logic [VERD_W-1:0]    verdict;
    logic [HOP_W-1:0]     hop;
    logic [CNT_OUT_W-1:0] stronger;
  } verdict_t;

  verdict_t    pending_verdicts[$];
  int          errors;
  int          min_rssi;
  int unsigned pref_count;
  bit [31:0]   tmo_limit;
  bit          seen_ok[SEEN_DEPTH_DEF];
  bit [55:0]   seen_call[SEEN_DEPTH_DEF];
  bit [15:0]   seen_id[SEEN_DEPTH_DEF];
  int          seen_ptr;
  bit          nbr_ok[NEIGHBOR_DEPTH_DEF];
  bit [55:0]   nbr_call[NEIGHBOR_DEPTH_DEF];
  int          nbr_sig[NEIGHBOR_DEPTH_DEF];
  bit [31:0]   nbr_stamp[NEIGHBOR_DEPTH_DEF];

  function new();
    min_rssi = -105;
    pref_count = 3;
    tmo_limit = 60000;
    seen_ptr = 0;
    errors = 0;
    foreach (seen_ok[i]) seen_ok[i] = 0;
    foreach (nbr_ok[i]) begin
      nbr_ok[i] = 0;
      nbr_stamp[i] = 0;
    end
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    logic signed [SIG_W-1:0] s;
    s = data[SIG_W-1:0];
    case (idx)
      REG_MIN_RSSI: min_rssi = s;
      REG_PREF: pref_count = data[PREF_W-1:0];
      REG_TIMEOUT: tmo_limit = data;
      default: ;
    endcase
  endfunction

  function int pending();
    return pending_verdicts.size();
  endfunction

  // work out the verdict for one accepted word and update the tables
  function void note_frame(bit md, bit [55:0] call, bit [15:0] id, bit [7:0] hop,
                           int sig, bit [31:0] t);
    verdict_t v;
    bit dup;
    bit done;
    int slot;
    bit [31:0] age;
    v.hop = hop;
    v.stronger = 0;
    dup = 0;
    done = 0;
    if (md) begin
      // cleanup: forget neighbors silent for too long
      for (int i = 0; i < NEIGHBOR_DEPTH_DEF; i++) begin
        age = t - nbr_stamp[i];
        if (nbr_ok[i] && age > tmo_limit) nbr_ok[i] = 0;
      end
      v.verdict = VERD_CLEAN;
    end else begin
      for (int i = 0; i < SEEN_DEPTH_DEF; i++)
        if (seen_ok[i] && seen_call[i] == call && seen_id[i] == id) dup = 1;
      if (dup) begin
        v.verdict = VERD_DUP;
      end else begin
        seen_ok[seen_ptr] = 1;
        seen_call[seen_ptr] = call;
        seen_id[seen_ptr] = id;
        seen_ptr = (seen_ptr + 1) % SEEN_DEPTH_DEF;
        // refresh, else fill free slot, else replace smallest stamp
        for (int i = 0; i < NEIGHBOR_DEPTH_DEF && !done; i++)
          if (nbr_ok[i] && nbr_call[i] == call) begin
            nbr_sig[i] = sig;
            nbr_stamp[i] = t;
            done = 1;
          end
        slot = -1;
        for (int i = 0; i < NEIGHBOR_DEPTH_DEF && !done && slot < 0; i++)
          if (!nbr_ok[i]) slot = i;
        if (!done && slot < 0) begin
          slot = 0;
          for (int i = 1; i < NEIGHBOR_DEPTH_DEF; i++)
            if (nbr_stamp[i] < nbr_stamp[slot]) slot = i;
        end
        if (!done) begin
          nbr_ok[slot] = 1;
          nbr_call[slot] = call;
          nbr_sig[slot] = sig;
          nbr_stamp[slot] = t;
        end
        if (hop <= 1) begin
          v.verdict = VERD_HOP;
        end else if (sig < min_rssi) begin
          v.verdict = VERD_WEAK;
        end else begin
          int unsigned n;
          n = 0;
          for (int i = 0; i < NEIGHBOR_DEPTH_DEF; i++)
            if (nbr_ok[i] && nbr_sig[i] > sig) n++;
          v.stronger = CNT_OUT_W'(n);
          if (n < pref_count) begin
            v.verdict = VERD_FWD;
            v.hop = HOP_W'(hop - 1);
          end else begin
            v.verdict = VERD_NOTPREF;
          end
        end
      end
    end
    pending_verdicts.push_back(v);
  endfunction

  function void check_verdict(logic [VERD_W-1:0] verd, logic [HOP_W-1:0] hop,
                              logic [CNT_OUT_W-1:0] cnt);
    verdict_t e;
    if (pending_verdicts.size() == 0) begin
      $error("unexpected verdict word %0d", verd);
      errors++;
      return;
    end
    e = pending_verdicts.pop_front();
    if (verd !== e.verdict) begin
      $error("verdict: expected %0d, got %0d", e.verdict, verd);
      errors++;
    end
    if (hop !== e.hop) begin
      $error("hop_out: expected %0d, got %0d", e.hop, hop);
      errors++;
    end
    if (cnt !== e.stronger) begin
      $error("stronger_count: expected %0d, got %0d", e.stronger, cnt);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 900000;
  localparam int DRAIN_CYCLES = 80;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    mode = 1'b0;
  logic [CALL_W-1:0]       src_call = '0;
  logic [ID_W-1:0]         message_id = '0;
  logic [HOP_W-1:0]        hop_limit = '0;
  logic signed [SIG_W-1:0] signal_dbm = '0;
  logic [TIME_W-1:0]       time_ms = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [VERD_W-1:0]       verdict;
  logic [HOP_W-1:0]        hop_out;
  logic [CNT_OUT_W-1:0]    stronger_count;

  forward_scoreboard sb = new();
  int        cycles = 0;
  bit        calm = 0;
  int        stall_left = 0;
  bit [31:0] now_ms = 0;
  bit [55:0] call_pool[24];
  bit [55:0] last_call;
  bit [15:0] last_id;

  flood_forward_filter_unit dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver side with stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result word monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_verdict(verdict, hop_out, stronger_count);
  end

  task automatic send_word(bit md, bit [55:0] call, bit [15:0] id, bit [7:0] hop,
                           int sig, bit [31:0] t);
    int gap;
    in_valid <= 1'b1;
    mode <= md;
    src_call <= call;
    message_id <= id;
    hop_limit <= hop;
    signal_dbm <= SIG_W'(sig);
    time_ms <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_frame(md, call, id, hop, sig, t);
    last_call = call;
    last_id = id;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_regs(int rssi, int pref, bit [31:0] tmo);
    logic [31:0] d;
    d = rssi;
    write_reg(REG_MIN_RSSI, d);
    write_reg(REG_PREF, pref);
    write_reg(REG_TIMEOUT, tmo);
  endtask

  // one random phase: mostly frames from a small call pool
  task automatic random_phase(int count);
    bit [55:0] c;
    bit [15:0] id;
    bit [7:0]  hop;
    int        sig;
    int        r;
    foreach (call_pool[i]) call_pool[i] = {$urandom, $urandom} & 56'hFFFFFFFFFFFFFF;
    call_pool[0] = '0;
    call_pool[1] = '1;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) now_ms = $urandom;
      else now_ms = now_ms + $urandom_range(0, 9000);
      if (r < 8) begin
        send_word(1'b1, {$urandom, $urandom}, $urandom, $urandom, $urandom_range(0, 255) - 157,
                  now_ms);
      end else begin
        c = call_pool[$urandom_range(0, 23)];
        id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
        if (r < 25) begin
          c = last_call;
          id = last_id;
        end
        case ($urandom_range(0, 9))
          0: hop = $urandom_range(0, 1);
          1: hop = 8'hFF;
          default: hop = $urandom_range(2, 255);
        endcase
        sig = $urandom_range(0, 255) - 157;
        send_word(1'b0, c, id, hop, sig, now_ms);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at reset settings
    send_word(1'b0, 56'h0, 16'h0, 8'd0, -157, 32'h0);
    send_word(1'b0, 56'hFFFFFFFFFFFFFF, 16'hFFFF, 8'd1, 98, 32'h10);
    send_word(1'b0, 56'h41424344454647, 16'h0001, 8'd2, -105, 32'h20);
    send_word(1'b0, 56'h41424344454647, 16'h0001, 8'd2, -105, 32'h21);
    send_word(1'b0, 56'h31323334353637, 16'h0002, 8'd255, -106, 32'h30);
    send_word(1'b0, 56'h11111111111111, 16'h0003, 8'd200, 98, 32'hFFFF0000);
    send_word(1'b0, 56'h22222222222222, 16'h0004, 8'd9, -120, 32'hFFFFFFFF);
    send_word(1'b0, 56'h33333333333333, 16'h0005, 8'd9, -150, 32'h40);
    send_word(1'b0, 56'h44444444444444, 16'h0006, 8'd9, -157, 32'h50);
    send_word(1'b0, 56'h55555555555555, 16'h0007, 8'd9, -157, 32'h60);
    send_word(1'b0, 56'hFFFFFFFFFFFFFF, 16'h0008, 8'd3, 20, 32'h70);
    send_word(1'b1, 56'h0, 16'h0, 8'd7, 0, 32'h0000EA00);
    send_word(1'b1, 56'hFFFFFFFFFFFFFF, 16'hFFFF, 8'hFF, -1, 32'h00010000);
    send_word(1'b0, 56'h0, 16'h0, 8'd0, -157, 32'h00020000);
    for (int i = 0; i < 8; i++)
      send_word(1'b0, 56'h60 + i, 16'h100 + i, 8'd5, -60 + i, 32'h00030000 + i);
    wait_idle();

    // extremes of the thresholds, random settings, then the reset values again
    set_regs(-157, 0, 32'h0);
    random_phase(120);
    wait_idle();
    set_regs(98, 31, 32'hFFFFFFFF);
    random_phase(120);
    wait_idle();
    set_regs(-157, 20, 32'd1000);
    random_phase(150);
    wait_idle();
    set_regs($urandom_range(0, 255) - 157, $urandom_range(0, 20), $urandom_range(0, 30000));
    random_phase(150);
    wait_idle();
    set_regs(-105, 3, 32'd60000);
    random_phase(288);
    calm = 1;
    random_phase(100);

    wait_idle();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
